/* sv/cda_pkg.sv */
package cda_pkg;

   // field widths
   localparam int DAY_W    = 5;
   localparam int MONTH_W  = 4;
   localparam int YEAR_W   = 12;
   localparam int DNUM_W   = 21;
   localparam int HOUR_W   = 25;
   localparam int ORDER_W  = 2;

   // command codes
   localparam logic [1:0] CMD_ADD     = 2'd0;
   localparam logic [1:0] CMD_SUB     = 2'd1;
   localparam logic [1:0] CMD_DIFF    = 2'd2;
   localparam logic [1:0] CMD_COMPARE = 2'd3;

   // compare outcomes
   localparam logic [ORDER_W-1:0] ORDER_EQUAL  = 2'd0;
   localparam logic [ORDER_W-1:0] ORDER_A_LATE = 2'd1;
   localparam logic [ORDER_W-1:0] ORDER_B_LATE = 2'd2;

   // calendar limits
   localparam logic [YEAR_W-1:0]  MaxYear   = 12'd4095;
   localparam logic [YEAR_W-1:0]  CenturyBase = 12'd2000;
   // day number of 31 December of the last year
   localparam logic [DNUM_W-1:0]  DayTop    = 21'd1496033;
   // 2^20 * 400 / 146097, rounded: first guess of the year from a day number
   localparam logic [11:0]        YearRecip = 12'd2871;
   // 2^19 / 100, rounded up: exact quotient for values below 43690
   localparam logic [12:0]        HundredRecip = 13'd5243;

   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
   } date_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DAYNUM,
      ST_EXEC,
      ST_ESTIMATE,
      ST_YEAR_FIX,
      ST_SUB_YEAR,
      ST_MONTH_WALK,
      ST_DONE
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load;
      logic daynum;
      logic exec;
      logic estimate;
      logic year_step;
      logic sub_year;
      logic month_step;
   } ctl_type;

   // status from datapath to controller
   typedef struct packed {
      logic is_date;
      logic year_done;
      logic month_done;
   } stat_type;

   // quotient by 100 through a reciprocal multiply
   function automatic logic [5:0] div100(input logic [12:0] v);
      logic [25:0] prod;
      prod = {13'b0, v} * {13'b0, HundredRecip};
      return prod[24:19];
   endfunction

   function automatic logic is_leap(input logic [YEAR_W-1:0] y);
      logic [5:0]  q;
      logic [12:0] cent;
      logic        whole;
      q     = div100({1'b0, y});
      cent  = 13'(q) * 13'd100;
      whole = ({1'b0, y} == cent);
      return ((y[1:0] == 2'd0) && !whole) || (whole && (q[1:0] == 2'd0));
   endfunction

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      len = 5'd31;
      if (m inside {4'd4, 4'd6, 4'd9, 4'd11})
         len = 5'd30;
      else if (m == 4'd2)
         len = leap ? 5'd29 : 5'd28;
      return len;
   endfunction

   // days before the first of the month in a common year
   function automatic logic [8:0] month_start(input logic [MONTH_W-1:0] m);
      logic [8:0] s;
      case (m)
         4'd2:    s = 9'd31;
         4'd3:    s = 9'd59;
         4'd4:    s = 9'd90;
         4'd5:    s = 9'd120;
         4'd6:    s = 9'd151;
         4'd7:    s = 9'd181;
         4'd8:    s = 9'd212;
         4'd9:    s = 9'd243;
         4'd10:   s = 9'd273;
         4'd11:   s = 9'd304;
         4'd12:   s = 9'd334;
         default: s = 9'd0;
      endcase
      return s;
   endfunction

   // days from 1 January of year 0 to 1 January of year y
   function automatic logic [DNUM_W-1:0] days_before_year(input logic [12:0] y);
      logic [21:0] base;
      logic [10:0] q4;
      logic [5:0]  q100;
      logic [5:0]  q400;
      base = 22'(y) * 22'd365;
      q4   = 11'((y + 13'd3) >> 2);
      q100 = div100(y + 13'd99);
      q400 = div100(y + 13'd399) >> 2;
      return DNUM_W'(base + 22'(q4) - 22'(q100) + 22'(q400));
   endfunction

   // fold short years into this century and clamp month and day
   function automatic date_type normalize(input logic [DAY_W-1:0] d,
                                          input logic [MONTH_W-1:0] m,
                                          input logic [YEAR_W-1:0] y);
      date_type         r;
      logic [DAY_W-1:0] len;
      r.year  = (y < 12'd100) ? y + CenturyBase : y;
      r.month = (m == 4'd0) ? 4'd1 : ((m > 4'd12) ? 4'd12 : m);
      len     = month_len(r.month, is_leap(r.year));
      r.day   = (d == 5'd0) ? 5'd1 : ((d > len) ? len : d);
      return r;
   endfunction

   function automatic logic [DNUM_W-1:0] day_number(input date_type dt);
      logic leap_adj;
      leap_adj = is_leap(dt.year) && (dt.month > 4'd2);
      return days_before_year({1'b0, dt.year}) + DNUM_W'(month_start(dt.month))
             + DNUM_W'(leap_adj) + DNUM_W'(dt.day) - DNUM_W'(1);
   endfunction

endpackage

/* sv/cda_ctrl.sv */
module cda_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  cda_pkg::stat_type   stat,
   output cda_pkg::ctl_type    ctl,
   output logic                busy,
   output logic                rsp_valid
);

   cda_pkg::state_type state_ff;
   cda_pkg::state_type state_in;

   // hold the state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cda_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // sequence one request through conversion, operation and, for add and subtract, date rebuild
   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         cda_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               ctl.load = 1'b1;
               state_in = cda_pkg::ST_DAYNUM;
            end
         end
         cda_pkg::ST_DAYNUM: begin
            ctl.daynum = 1'b1;
            state_in   = cda_pkg::ST_EXEC;
         end
         cda_pkg::ST_EXEC: begin
            ctl.exec = 1'b1;
            state_in = stat.is_date ? cda_pkg::ST_ESTIMATE : cda_pkg::ST_DONE;
         end
         cda_pkg::ST_ESTIMATE: begin
            ctl.estimate = 1'b1;
            state_in     = cda_pkg::ST_YEAR_FIX;
         end
         cda_pkg::ST_YEAR_FIX: begin
            ctl.year_step = 1'b1;
            if (stat.year_done)
               state_in = cda_pkg::ST_SUB_YEAR;
         end
         cda_pkg::ST_SUB_YEAR: begin
            ctl.sub_year = 1'b1;
            state_in     = cda_pkg::ST_MONTH_WALK;
         end
         cda_pkg::ST_MONTH_WALK: begin
            ctl.month_step = 1'b1;
            if (stat.month_done)
               state_in = cda_pkg::ST_DONE;
         end
         cda_pkg::ST_DONE: begin
            rsp_valid = 1'b1;
            state_in  = cda_pkg::ST_IDLE;
         end
         default: begin
            state_in = cda_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

/* sv/cda_datapath.sv */
module cda_datapath #(
   parameter int AMOUNT_WIDTH = 16
) (
   input  logic                              clock,
   input  cda_pkg::ctl_type                  ctl,
   output cda_pkg::stat_type                 stat,
   input  logic [1:0]                        req_command,
   input  logic [cda_pkg::DAY_W-1:0]         req_day_a,
   input  logic [cda_pkg::MONTH_W-1:0]       req_month_a,
   input  logic [cda_pkg::YEAR_W-1:0]        req_year_a,
   input  logic [cda_pkg::DAY_W-1:0]         req_day_b,
   input  logic [cda_pkg::MONTH_W-1:0]       req_month_b,
   input  logic [cda_pkg::YEAR_W-1:0]        req_year_b,
   input  logic [AMOUNT_WIDTH-1:0]           req_day_amount,
   output logic [cda_pkg::DAY_W-1:0]         rsp_res_day,
   output logic [cda_pkg::MONTH_W-1:0]       rsp_res_month,
   output logic [cda_pkg::YEAR_W-1:0]        rsp_res_year,
   output logic [cda_pkg::DNUM_W-1:0]        rsp_day_count,
   output logic [cda_pkg::HOUR_W-1:0]        rsp_hour_count,
   output logic [cda_pkg::ORDER_W-1:0]       rsp_order,
   output logic                              rsp_range_error
);

   localparam int SUM_W = ((AMOUNT_WIDTH > cda_pkg::DNUM_W) ?
                           AMOUNT_WIDTH : cda_pkg::DNUM_W) + 1;

   logic [1:0]                   cmd_ff, cmd_in;
   cda_pkg::date_type            date_a_ff, date_a_in;
   cda_pkg::date_type            date_b_ff, date_b_in;
   logic [AMOUNT_WIDTH-1:0]      amt_ff, amt_in;
   logic [cda_pkg::DNUM_W-1:0]   num_a_ff, num_a_in;
   logic [cda_pkg::DNUM_W-1:0]   num_b_ff, num_b_in;
   logic [cda_pkg::DNUM_W-1:0]   n_ff, n_in;
   logic [cda_pkg::YEAR_W-1:0]   y_ff, y_in;
   logic [cda_pkg::MONTH_W-1:0]  m_ff, m_in;
   logic [cda_pkg::DNUM_W-1:0]   day_count_ff, day_count_in;
   logic [cda_pkg::HOUR_W-1:0]   hour_count_ff, hour_count_in;
   logic [cda_pkg::ORDER_W-1:0]  order_ff, order_in;
   logic                         range_ff, range_in;

   logic                         is_date;
   logic [SUM_W-1:0]             a_ext, amt_ext, sum;
   logic [cda_pkg::DNUM_W-1:0]   diff;
   logic [25:0]                  hours;
   logic [32:0]                  est_prod;
   logic [12:0]                  est_year;
   logic [cda_pkg::DNUM_W-1:0]   dby_y, dby_next;
   logic                         year_dec, year_inc;
   logic [cda_pkg::DAY_W-1:0]    len_m;
   logic                         month_more;

   assign is_date = (cmd_ff == cda_pkg::CMD_ADD) || (cmd_ff == cda_pkg::CMD_SUB);

   // operations on the day numbers and the day amount
   assign a_ext   = SUM_W'(num_a_ff);
   assign amt_ext = SUM_W'(amt_ff);
   assign sum     = a_ext + amt_ext;
   assign diff    = (num_a_ff > num_b_ff) ? num_a_ff - num_b_ff : num_b_ff - num_a_ff;
   assign hours   = 26'({diff, 4'b0}) + 26'({diff, 3'b0});

   // first guess of the year, clamped to the last year
   assign est_prod = 33'(n_ff) * 33'(cda_pkg::YearRecip);
   assign est_year = est_prod[32:20];

   // one year correction a cycle, lowering first
   assign dby_y    = cda_pkg::days_before_year({1'b0, y_ff});
   assign dby_next = cda_pkg::days_before_year(13'(y_ff) + 13'd1);
   assign year_dec = (y_ff != 12'd0) && (dby_y > n_ff);
   assign year_inc = !year_dec && (y_ff != cda_pkg::MaxYear) && (dby_next <= n_ff);

   // one month a cycle through the remaining days of the year
   assign len_m      = cda_pkg::month_len(m_ff, cda_pkg::is_leap(y_ff));
   assign month_more = (m_ff < 4'd12) && (n_ff >= cda_pkg::DNUM_W'(len_m));

   assign stat.is_date    = is_date;
   assign stat.year_done  = !year_dec && !year_inc;
   assign stat.month_done = !month_more;

   // next values of the working registers
   always_comb begin
      cmd_in        = cmd_ff;
      date_a_in     = date_a_ff;
      date_b_in     = date_b_ff;
      amt_in        = amt_ff;
      num_a_in      = num_a_ff;
      num_b_in      = num_b_ff;
      n_in          = n_ff;
      y_in          = y_ff;
      m_in          = m_ff;
      day_count_in  = day_count_ff;
      hour_count_in = hour_count_ff;
      order_in      = order_ff;
      range_in      = range_ff;

      if (ctl.load) begin
         cmd_in    = req_command;
         date_a_in = cda_pkg::normalize(req_day_a, req_month_a, req_year_a);
         date_b_in = cda_pkg::normalize(req_day_b, req_month_b, req_year_b);
         amt_in    = req_day_amount;
      end

      if (ctl.daynum) begin
         num_a_in = cda_pkg::day_number(date_a_ff);
         num_b_in = cda_pkg::day_number(date_b_ff);
      end

      if (ctl.exec) begin
         day_count_in  = '0;
         hour_count_in = '0;
         order_in      = cda_pkg::ORDER_EQUAL;
         range_in      = 1'b0;
         n_in          = '0;
         case (cmd_ff)
            cda_pkg::CMD_ADD: begin
               if (sum > SUM_W'(cda_pkg::DayTop)) begin
                  n_in     = cda_pkg::DayTop;
                  range_in = 1'b1;
               end else begin
                  n_in = cda_pkg::DNUM_W'(sum);
               end
            end
            cda_pkg::CMD_SUB: begin
               if (amt_ext > a_ext) begin
                  range_in = 1'b1;
               end else begin
                  n_in = cda_pkg::DNUM_W'(a_ext - amt_ext);
               end
            end
            cda_pkg::CMD_DIFF: begin
               day_count_in  = diff;
               hour_count_in = hours[25] ? '1 : hours[24:0];
            end
            cda_pkg::CMD_COMPARE: begin
               if (num_a_ff > num_b_ff)
                  order_in = cda_pkg::ORDER_A_LATE;
               else if (num_a_ff < num_b_ff)
                  order_in = cda_pkg::ORDER_B_LATE;
            end
            default: begin
               order_in = cda_pkg::ORDER_EQUAL;
            end
         endcase
      end

      if (ctl.estimate)
         y_in = est_year[12] ? cda_pkg::MaxYear : est_year[11:0];

      if (ctl.year_step) begin
         if (year_dec)
            y_in = y_ff - 12'd1;
         else if (year_inc)
            y_in = y_ff + 12'd1;
      end

      if (ctl.sub_year) begin
         n_in = n_ff - dby_y;
         m_in = 4'd1;
      end

      if (ctl.month_step && month_more) begin
         n_in = n_ff - cda_pkg::DNUM_W'(len_m);
         m_in = m_ff + 4'd1;
      end
   end

   // hold the working registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      date_a_ff     <= date_a_in;
      date_b_ff     <= date_b_in;
      amt_ff        <= amt_in;
      num_a_ff      <= num_a_in;
      num_b_ff      <= num_b_in;
      n_ff          <= n_in;
      y_ff          <= y_in;
      m_ff          <= m_in;
      day_count_ff  <= day_count_in;
      hour_count_ff <= hour_count_in;
      order_ff      <= order_in;
      range_ff      <= range_in;
   end

   // drive the result, date fields only for add and subtract
   assign rsp_res_day     = is_date ? 5'(n_ff + 21'd1) : '0;
   assign rsp_res_month   = is_date ? m_ff : '0;
   assign rsp_res_year    = is_date ? y_ff : '0;
   assign rsp_day_count   = day_count_ff;
   assign rsp_hour_count  = hour_count_ff;
   assign rsp_order       = order_ff;
   assign rsp_range_error = range_ff;

endmodule

/* sv/calendar_date_arithmetic.sv */
// Channel   Direction  Handshake              Payload
// request   in         start high, busy low   req_command, req_day_a .. req_day_amount
// response  out        rsp_valid, one cycle   rsp_res_day .. rsp_range_error
//
// Difference and compare pass the day-number and execute states before rsp_valid.
// Add and subtract go on to a year guess, at most one one-year
// correction and a walk of up to eleven months, one month a cycle.
// Synchronous active-high reset returns the controller to idle.
// busy stays high until the response cycle ends; the response is never stalled.
module calendar_date_arithmetic #(
   parameter int AMOUNT_WIDTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_command,
   input  logic [cda_pkg::DAY_W-1:0]         req_day_a,
   input  logic [cda_pkg::MONTH_W-1:0]       req_month_a,
   input  logic [cda_pkg::YEAR_W-1:0]        req_year_a,
   input  logic [cda_pkg::DAY_W-1:0]         req_day_b,
   input  logic [cda_pkg::MONTH_W-1:0]       req_month_b,
   input  logic [cda_pkg::YEAR_W-1:0]        req_year_b,
   input  logic [AMOUNT_WIDTH-1:0]           req_day_amount,
   output logic                              rsp_valid,
   output logic [cda_pkg::DAY_W-1:0]         rsp_res_day,
   output logic [cda_pkg::MONTH_W-1:0]       rsp_res_month,
   output logic [cda_pkg::YEAR_W-1:0]        rsp_res_year,
   output logic [cda_pkg::DNUM_W-1:0]        rsp_day_count,
   output logic [cda_pkg::HOUR_W-1:0]        rsp_hour_count,
   output logic [cda_pkg::ORDER_W-1:0]       rsp_order,
   output logic                              rsp_range_error
);

   cda_pkg::ctl_type  ctl;
   cda_pkg::stat_type stat;

   // sequence each request
   cda_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (stat),
      .ctl       (ctl),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // convert, operate and rebuild the date
   cda_datapath #(
      .AMOUNT_WIDTH (AMOUNT_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .ctl             (ctl),
      .stat            (stat),
      .req_command     (req_command),
      .req_day_a       (req_day_a),
      .req_month_a     (req_month_a),
      .req_year_a      (req_year_a),
      .req_day_b       (req_day_b),
      .req_month_b     (req_month_b),
      .req_year_b      (req_year_b),
      .req_day_amount  (req_day_amount),
      .rsp_res_day     (rsp_res_day),
      .rsp_res_month   (rsp_res_month),
      .rsp_res_year    (rsp_res_year),
      .rsp_day_count   (rsp_day_count),
      .rsp_hour_count  (rsp_hour_count),
      .rsp_order       (rsp_order),
      .rsp_range_error (rsp_range_error)
   );

endmodule

/* dv/date_unit_checker.sv */
module date_unit_checker #(
   parameter int AMOUNT_WIDTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         busy,
   input  logic [1:0]                   req_command,
   input  logic [cda_pkg::DAY_W-1:0]    req_day_a,
   input  logic [cda_pkg::MONTH_W-1:0]  req_month_a,
   input  logic [cda_pkg::YEAR_W-1:0]   req_year_a,
   input  logic [cda_pkg::DAY_W-1:0]    req_day_b,
   input  logic [cda_pkg::MONTH_W-1:0]  req_month_b,
   input  logic [cda_pkg::YEAR_W-1:0]   req_year_b,
   input  logic [AMOUNT_WIDTH-1:0]      req_day_amount,
   input  logic                         rsp_valid,
   input  logic [cda_pkg::DAY_W-1:0]    rsp_res_day,
   input  logic [cda_pkg::MONTH_W-1:0]  rsp_res_month,
   input  logic [cda_pkg::YEAR_W-1:0]   rsp_res_year,
   input  logic [cda_pkg::DNUM_W-1:0]   rsp_day_count,
   input  logic [cda_pkg::HOUR_W-1:0]   rsp_hour_count,
   input  logic [cda_pkg::ORDER_W-1:0]  rsp_order,
   input  logic                         rsp_range_error,
   output int                           mismatches,
   output int                           outstanding
);
   import cda_pkg::*;

   localparam int LAST_YEAR = 4095;
   localparam longint unsigned HOUR_CEILING = (64'd1 << HOUR_W) - 1;

   typedef struct {
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
      logic [DNUM_W-1:0]  day_count;
      logic [HOUR_W-1:0]  hour_count;
      logic [ORDER_W-1:0] order;
      logic               range_error;
   } date_reply_type;

   date_reply_type replies_due[$];

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   function automatic bit leap_year(int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic int unsigned month_days(int unsigned m, int unsigned y);
      case (m)
         4, 6, 9, 11: return 30;
         2:           return leap_year(y) ? 29 : 28;
         default:     return 31;
      endcase
   endfunction

   // days from 1 January of year 0 up to 1 January of year y
   function automatic int unsigned year_start(int unsigned y);
      return 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
   endfunction

   // fold short years, clamp month and day, then count days from year 0
   function automatic int unsigned serial_of(logic [DAY_W-1:0] d, logic [MONTH_W-1:0] m,
                                             logic [YEAR_W-1:0] y);
      int unsigned yy, mm, dd, n, k;
      yy = 32'(y);
      mm = 32'(m);
      dd = 32'(d);
      if (yy < 100) yy += 2000;
      if (mm < 1) mm = 1;
      if (mm > 12) mm = 12;
      if (dd < 1) dd = 1;
      if (dd > month_days(mm, yy)) dd = month_days(mm, yy);
      n = year_start(yy);
      for (k = 1; k < mm; k++)
         n += month_days(k, yy);
      return n + dd - 1;
   endfunction

   // turn a day count back into a calendar date
   function automatic void date_of(int unsigned n, ref date_reply_type r);
      longint unsigned wide;
      int unsigned     yy, mm, rest;
      wide = 64'(n);
      yy   = int'((wide * 400) / 146097);
      if (yy > LAST_YEAR) yy = LAST_YEAR;
      while (yy > 0 && year_start(yy) > n) yy--;
      while (yy < LAST_YEAR && year_start(yy + 1) <= n) yy++;
      rest = n - year_start(yy);
      mm   = 1;
      while (mm < 12 && rest >= month_days(mm, yy)) begin
         rest -= month_days(mm, yy);
         mm++;
      end
      r.day   = DAY_W'(rest + 1);
      r.month = MONTH_W'(mm);
      r.year  = YEAR_W'(yy);
   endfunction

   function automatic date_reply_type work_out_reply(
      logic [1:0] cmd,
      logic [DAY_W-1:0] da, logic [MONTH_W-1:0] ma, logic [YEAR_W-1:0] ya,
      logic [DAY_W-1:0] db, logic [MONTH_W-1:0] mb, logic [YEAR_W-1:0] yb,
      logic [AMOUNT_WIDTH-1:0] amount);
      date_reply_type  r;
      int unsigned     a, b, span, latest, target;
      longint unsigned hours;
      r     = '{default: '0};
      a     = serial_of(da, ma, ya);
      b     = serial_of(db, mb, yb);
      latest = year_start(LAST_YEAR + 1) - 1;
      case (cmd)
         CMD_ADD: begin
            target = a + 32'(amount);
            if (target > latest) begin
               target        = latest;
               r.range_error = 1'b1;
            end
            date_of(target, r);
         end
         CMD_SUB: begin
            if (32'(amount) > a) begin
               target        = 0;
               r.range_error = 1'b1;
            end else begin
               target = a - 32'(amount);
            end
            date_of(target, r);
         end
         CMD_DIFF: begin
            span        = (a > b) ? a - b : b - a;
            hours       = longint'(span) * 24;
            r.day_count = DNUM_W'(span);
            r.hour_count = (hours > HOUR_CEILING) ? HOUR_CEILING[HOUR_W-1:0]
                                                   : HOUR_W'(hours);
         end
         default: begin
            r.order = (a == b) ? ORDER_EQUAL : ((a > b) ? ORDER_A_LATE : ORDER_B_LATE);
         end
      endcase
      return r;
   endfunction

   task automatic check_field(string what, logic [31:0] want_v, logic [31:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t %s: expected %0d, actual %0d", $time, what, want_v, got_v);
         mismatches++;
      end
   endtask

   // compare results first, then log the request taken at this edge
   always @(posedge clock) begin
      date_reply_type want;
      if (!reset) begin
         if (rsp_valid === 1'b1) begin
            if (replies_due.size() == 0) begin
               $display("%0t unrequested result: expected none, actual %0d/%0d/%0d",
                        $time, rsp_res_day, rsp_res_month, rsp_res_year);
               mismatches++;
            end else begin
               want = replies_due.pop_front();
               check_field("res_day", 32'(want.day), 32'(rsp_res_day));
               check_field("res_month", 32'(want.month), 32'(rsp_res_month));
               check_field("res_year", 32'(want.year), 32'(rsp_res_year));
               check_field("day_count", 32'(want.day_count), 32'(rsp_day_count));
               check_field("hour_count", 32'(want.hour_count), 32'(rsp_hour_count));
               check_field("order", 32'(want.order), 32'(rsp_order));
               check_field("range_error", 32'(want.range_error), 32'(rsp_range_error));
            end
         end
         if (start === 1'b1 && busy === 1'b0)
            replies_due.push_back(work_out_reply(req_command,
                                                 req_day_a, req_month_a, req_year_a,
                                                 req_day_b, req_month_b, req_year_b,
                                                 req_day_amount));
         outstanding = replies_due.size();
      end
   end

endmodule

/* dv/tb.sv */
module tb;
   import cda_pkg::*;

   localparam int AMOUNT_WIDTH    = 16;
   localparam int RANDOM_REQUESTS = 100;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int DRAIN_CYCLES    = 24;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic [1:0]              req_command;
   logic [DAY_W-1:0]        req_day_a, req_day_b;
   logic [MONTH_W-1:0]      req_month_a, req_month_b;
   logic [YEAR_W-1:0]       req_year_a, req_year_b;
   logic [AMOUNT_WIDTH-1:0] req_day_amount;
   logic                    rsp_valid;
   logic [DAY_W-1:0]        rsp_res_day;
   logic [MONTH_W-1:0]      rsp_res_month;
   logic [YEAR_W-1:0]       rsp_res_year;
   logic [DNUM_W-1:0]       rsp_day_count;
   logic [HOUR_W-1:0]       rsp_hour_count;
   logic [ORDER_W-1:0]      rsp_order;
   logic                    rsp_range_error;

   int mismatches;
   int outstanding;
   int idle_cycles = 0;
   int per_command[4];
   bit back_to_back = 1'b0;

   always #1 clock = ~clock;

   calendar_date_arithmetic #(.AMOUNT_WIDTH(AMOUNT_WIDTH)) u_dut (.*);

   date_unit_checker #(.AMOUNT_WIDTH(AMOUNT_WIDTH)) u_checker (.*);

   // stop the run if the channels go quiet for too long
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // hold start low for a drawn gap, then present a request until it is taken
   task automatic issue(input logic [1:0] cmd,
                        input logic [DAY_W-1:0] da, input logic [MONTH_W-1:0] ma,
                        input logic [YEAR_W-1:0] ya,
                        input logic [DAY_W-1:0] db, input logic [MONTH_W-1:0] mb,
                        input logic [YEAR_W-1:0] yb,
                        input logic [AMOUNT_WIDTH-1:0] amount);
      int gap;
      gap = back_to_back ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         @(negedge clock) start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_command    <= cmd;
      req_day_a      <= da;
      req_month_a    <= ma;
      req_year_a     <= ya;
      req_day_b      <= db;
      req_month_b    <= mb;
      req_year_b     <= yb;
      req_day_amount <= amount;
      start          <= 1'b1;
      do @(posedge clock); while (busy);
      per_command[cmd]++;
   endtask

   // day 1 to 31 and month 1 to 12, mostly in the ordinary range, sometimes a short year
   function automatic void random_date(output logic [DAY_W-1:0] d,
                                       output logic [MONTH_W-1:0] m,
                                       output logic [YEAR_W-1:0] y);
      m = MONTH_W'($urandom_range(1, 12));
      d = $urandom_range(0, 1) ? DAY_W'($urandom_range(1, 28))
                               : DAY_W'($urandom_range(1, 31));
      y = ($urandom_range(0, 4) == 0) ? YEAR_W'($urandom_range(0, 99))
                                      : YEAR_W'($urandom_range(100, 3000));
   endfunction

   initial begin
      int                      i;
      int                      kind;
      logic [1:0]              cmd;
      logic [DAY_W-1:0]        da, db;
      logic [MONTH_W-1:0]      ma, mb;
      logic [YEAR_W-1:0]       ya, yb;
      logic [AMOUNT_WIDTH-1:0] amount;

      reset          = 1'b1;
      start          = 1'b0;
      req_command    = CMD_ADD;
      req_day_a      = '0;
      req_month_a    = '0;
      req_year_a     = '0;
      req_day_b      = '0;
      req_month_b    = '0;
      req_year_b     = '0;
      req_day_amount = '0;
      per_command    = '{default: 0};
      repeat (10) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // calendar edges: top and bottom saturation, leap rules, short years
      issue(CMD_ADD,  5'd1,  4'd1,  12'd0,    5'd1, 4'd1, 12'd0,   16'd0);
      issue(CMD_ADD,  5'd31, 4'd12, 12'd4095, 5'd1, 4'd1, 12'd0,   16'd0);
      issue(CMD_ADD,  5'd31, 4'd12, 12'd4095, 5'd1, 4'd1, 12'd0,   16'd1);
      issue(CMD_ADD,  5'd1,  4'd1,  12'd4000, 5'd1, 4'd1, 12'd0,   16'hFFFF);
      issue(CMD_SUB,  5'd1,  4'd1,  12'd100,  5'd1, 4'd1, 12'd0,   16'd36524);
      issue(CMD_SUB,  5'd1,  4'd1,  12'd100,  5'd1, 4'd1, 12'd0,   16'd36525);
      issue(CMD_SUB,  5'd1,  4'd1,  12'd100,  5'd1, 4'd1, 12'd0,   16'hFFFF);
      issue(CMD_ADD,  5'd28, 4'd2,  12'd1900, 5'd1, 4'd1, 12'd0,   16'd1);
      issue(CMD_ADD,  5'd28, 4'd2,  12'd0,    5'd1, 4'd1, 12'd0,   16'd1);
      issue(CMD_SUB,  5'd1,  4'd3,  12'd2100, 5'd1, 4'd1, 12'd0,   16'd1);
      issue(CMD_ADD,  5'd31, 4'd12, 12'd1999, 5'd1, 4'd1, 12'd0,   16'd1);
      issue(CMD_ADD,  5'd15, 4'd6,  12'd99,   5'd1, 4'd1, 12'd0,   16'd0);
      // difference: equal dates, hour saturation, short year against year 100
      issue(CMD_DIFF, 5'd15, 4'd6,  12'd24,   5'd15, 4'd6,  12'd24,  16'd0);
      issue(CMD_DIFF, 5'd31, 4'd12, 12'd4095, 5'd1,  4'd1,  12'd100, 16'd0);
      issue(CMD_DIFF, 5'd1,  4'd1,  12'd99,   5'd1,  4'd1,  12'd100, 16'd0);
      issue(CMD_DIFF, 5'd31, 4'd4,  12'd2023, 5'd30, 4'd4,  12'd2023, 16'd0);
      // compare: equal, first later, second later, all-ones against all-zeros
      issue(CMD_COMPARE, 5'd9, 4'd9, 12'd2020, 5'd9, 4'd9, 12'd20,   16'd0);
      issue(CMD_COMPARE, 5'd2, 4'd1, 12'd2020, 5'd1, 4'd1, 12'd2020, 16'd0);
      issue(CMD_COMPARE, 5'd1, 4'd1, 12'd150,  5'd1, 4'd1, 12'd0,    16'd0);
      issue(CMD_COMPARE, 5'd31, 4'd15, 12'd4095, 5'd0, 4'd0, 12'd0,  16'hFFFF);
      // out-of-range month and day get clamped
      issue(CMD_ADD,  5'd0,  4'd0,  12'd2024, 5'd1, 4'd1, 12'd0,   16'd0);
      issue(CMD_ADD,  5'd31, 4'd15, 12'd2023, 5'd1, 4'd1, 12'd0,   16'd0);
      issue(CMD_SUB,  5'd31, 4'd2,  12'd2023, 5'd1, 4'd1, 12'd0,   16'd0);

      for (i = 0; i < RANDOM_REQUESTS; i++) begin
         back_to_back = (i % 30) < 8;
         // let the block drain completely once, midway
         if (i == RANDOM_REQUESTS / 2) begin
            @(negedge clock) start <= 1'b0;
            wait (outstanding == 0);
         end
         kind = $urandom_range(0, 9);
         random_date(da, ma, ya);
         random_date(db, mb, yb);
         cmd    = 2'($urandom_range(0, 3));
         amount = $urandom_range(0, 1) ? AMOUNT_WIDTH'($urandom_range(0, 400))
                                       : AMOUNT_WIDTH'($urandom);
         case (kind)
            6: begin
               cmd = CMD_ADD;
               ya  = YEAR_W'($urandom_range(3910, 4095));
            end
            7: begin
               cmd = CMD_SUB;
               ya  = YEAR_W'($urandom_range(100, 280));
            end
            8, 9: begin
               cmd    = 2'($urandom);
               da     = DAY_W'($urandom);
               ma     = MONTH_W'($urandom);
               ya     = YEAR_W'($urandom);
               db     = DAY_W'($urandom);
               mb     = MONTH_W'($urandom);
               yb     = YEAR_W'($urandom);
               amount = AMOUNT_WIDTH'($urandom);
            end
            default: ;
         endcase
         issue(cmd, da, ma, ya, db, mb, yb, amount);
      end

      // drop start, wait out the last result and a short tail
      @(negedge clock) start <= 1'b0;
      wait (outstanding == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d add, %0d subtract, %0d difference and %0d compare requests,",
               per_command[CMD_ADD], per_command[CMD_SUB],
               per_command[CMD_DIFF], per_command[CMD_COMPARE]);
      $display("including saturation at both calendar ends and clamped fields.");
      if (mismatches == 0 && outstanding == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
